FILE: rtl/core/tbc_pkg.sv
// Shared types, constants and helpers for the tile map box collision block.
`timescale 1ns / 1ps

package tbc_pkg;

  // Tile size in pixels. It must be a power of two so that a tile index is a shift.
  localparam int TILE_PIXELS = 16;
  localparam int TILE_SHIFT  = $clog2(TILE_PIXELS * 256);

  // Request codes.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_MOVE  = 2'd2;

  // Configuration register indexes.
  localparam int         CFG_IDX_W = 2;
  localparam logic [1:0] CFG_AIR    = 2'd0;
  localparam logic [1:0] CFG_LEAVES = 2'd1;
  localparam logic [1:0] CFG_STONE  = 2'd2;

  localparam logic [7:0] AIR_RESET    = 8'd0;
  localparam logic [7:0] LEAVES_RESET = 8'd0;
  localparam logic [7:0] STONE_RESET  = 8'd3;

  typedef logic signed [15:0] tc_t;   // tile coordinate
  typedef logic signed [23:0] pos_t;  // Q.8 position or velocity
  typedef logic [14:0]        dim_t;  // Q.8 box size

  typedef struct packed {
    logic [7:0] air;
    logic [7:0] leaves;
    logic [7:0] stone;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic       we;
    tc_t        tx;
    tc_t        ty;
    logic [7:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] tile;
  } mem_rsp_t;

  typedef struct packed {
    logic [1:0]  req_type;
    tc_t         tile_x;
    tc_t         tile_y;
    logic [7:0]  tile_value;
    pos_t        box_x;
    pos_t        box_y;
    dim_t        box_w;
    dim_t        box_h;
    pos_t        vel_x;
    pos_t        vel_y;
    logic [15:0] step_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tile_out;
    pos_t       new_box_x;
    pos_t       new_box_y;
    pos_t       new_vel_x;
    pos_t       new_vel_y;
    logic       grounded;
  } out_item_t;

  // Clamp a wide signed value to the 24-bit signed range.
  function automatic pos_t sat24(input logic signed [28:0] v);
    pos_t r;
    if (v > 29'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -29'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tbc_if.sv
// Channel interfaces for requests, results and configuration writes.
`timescale 1ns / 1ps

interface tbc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] tile_x;
  logic signed [15:0] tile_y;
  logic [7:0]         tile_value;
  logic signed [23:0] box_x;
  logic signed [23:0] box_y;
  logic [14:0]        box_w;
  logic [14:0]        box_h;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;
  logic [15:0]        step_time;

  modport source (
    output valid, req_type, tile_x, tile_y, tile_value, box_x, box_y, box_w, box_h,
           vel_x, vel_y, step_time,
    input  ready
  );
  modport sink (
    input  valid, req_type, tile_x, tile_y, tile_value, box_x, box_y, box_w, box_h,
           vel_x, vel_y, step_time,
    output ready
  );
endinterface

interface tbc_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         tile_out;
  logic signed [23:0] new_box_x;
  logic signed [23:0] new_box_y;
  logic signed [23:0] new_vel_x;
  logic signed [23:0] new_vel_y;
  logic               grounded;

  modport source (
    output valid, tile_out, new_box_x, new_box_y, new_vel_x, new_vel_y, grounded,
    input  ready
  );
  modport sink (
    input  valid, tile_out, new_box_x, new_box_y, new_vel_x, new_vel_y, grounded,
    output ready
  );
endinterface

interface tbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tbc_cfg_regs.sv
// Configuration registers: the two non-solid tile codes and the outside-map code.
`timescale 1ns / 1ps

module tbc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_valid,
  input  logic [1:0]                wr_index,
  input  logic [7:0]                wr_data,
  output logic                      wr_ready,
  output tbc_pkg::cfg_t             cfg
);
  import tbc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      case (wr_index)
        CFG_AIR:    cfg_nxt.air    = wr_data;
        CFG_LEAVES: cfg_nxt.leaves = wr_data;
        CFG_STONE:  cfg_nxt.stone  = wr_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.air    <= AIR_RESET;
      cfg_r.leaves <= LEAVES_RESET;
      cfg_r.stone  <= STONE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/tbc_tile_store.sv
// Tile map memory with bounds check; coordinates outside the map read as the stone code.
`timescale 1ns / 1ps

module tbc_tile_store #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tbc_pkg::mem_req_t  req,
  input  logic [7:0]         stone_code,
  output tbc_pkg::mem_rsp_t  rsp
);
  import tbc_pkg::*;

  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    mem [DEPTH];
  logic          in_map;
  logic [31:0]   lin;
  logic [AW-1:0] addr;
  logic          rd_valid_r;
  logic          in_map_r;
  logic [7:0]    rdata_r;

  assign in_map = (int'(req.tx) >= 0) && (int'(req.tx) < MAP_WIDTH) &&
                  (int'(req.ty) >= 0) && (int'(req.ty) < MAP_HEIGHT);
  assign lin    = 32'($unsigned(req.ty)) * 32'(MAP_WIDTH) + 32'($unsigned(req.tx));
  assign addr   = lin[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.en && req.we && in_map) begin
      mem[addr] <= req.wdata;
    end
    if (req.en && !req.we && in_map) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= req.en && !req.we;
    end
    in_map_r <= in_map;
  end

  assign rsp.valid = rd_valid_r;
  assign rsp.tile  = in_map_r ? rdata_r : stone_code;

endmodule

FILE: rtl/core/tbc_ctrl.sv
// Request sequencer: tile writes and reads, and the two-axis move with tile span scans.
`timescale 1ns / 1ps

module tbc_ctrl #(
  parameter int MAX_SPAN_TILES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tbc_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tbc_pkg::out_item_t   out_item,
  input  tbc_pkg::cfg_t        cfg,
  output tbc_pkg::mem_req_t    mem_req,
  input  tbc_pkg::mem_rsp_t    mem_rsp
);
  import tbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_RD_ISSUE, S_RD_WAIT, S_MUL, S_POS,
    S_SETUP, S_SPAN, S_SCAN, S_SNAP, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         req_r, req_nxt;
  tc_t                tx_r, tx_nxt, ty_r, ty_nxt;
  logic [7:0]         wdata_r, wdata_nxt;
  pos_t               pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  pos_t               vx_r, vx_nxt, vy_r, vy_nxt;
  dim_t               w_r, w_nxt, h_r, h_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic signed [40:0] prod_r, prod_nxt;
  logic               axis_r, axis_nxt;
  tc_t                line_r, line_nxt, c_r, c_nxt, cend_r, cend_nxt;
  logic [7:0]         tile_res_r, tile_res_nxt;
  logic               gnd_r, gnd_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  // Current-axis views of the working registers (axis 0 is X, axis 1 is Y).
  pos_t               vel_sel, pos_sel, cross_pos;
  dim_t               lead_size, cross_size;
  logic signed [24:0] disp;
  logic signed [25:0] moved, lead_edge, cross_far;
  logic signed [28:0] face;
  tc_t                line_calc, c0_calc, c1_calc, span_lim;
  logic               issue, solid, load_out;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign vel_sel    = axis_r ? vy_r : vx_r;
  assign pos_sel    = axis_r ? pos_y_r : pos_x_r;
  assign cross_pos  = axis_r ? pos_x_r : pos_y_r;
  assign lead_size  = axis_r ? h_r : w_r;
  assign cross_size = axis_r ? w_r : h_r;

  // Displacement is the product shifted down by 16, rounding toward minus infinity.
  assign disp  = prod_r[40:16];
  assign moved = 26'(pos_sel) + 26'(disp);

  // Leading edge is the far side (pos + size) when moving in the positive direction.
  assign lead_edge = vel_sel[23] ? 26'(pos_sel)
                                 : 26'(pos_sel) + 26'($signed({1'b0, lead_size}));
  assign cross_far = 26'(cross_pos) + 26'($signed({1'b0, cross_size})) - 26'sd1;
  assign line_calc = tc_t'($signed(lead_edge[25:TILE_SHIFT]));
  assign c0_calc   = tc_t'($signed(cross_pos[23:TILE_SHIFT]));
  assign c1_calc   = tc_t'($signed(cross_far[25:TILE_SHIFT]));
  assign span_lim  = c_r + tc_t'(MAX_SPAN_TILES);

  assign face = vel_sel[23] ? ((29'(line_r) + 29'sd1) <<< TILE_SHIFT)
                            : ((29'(line_r) <<< TILE_SHIFT) - 29'($signed({1'b0, lead_size})));

  assign issue    = (c_r <= cend_r);
  assign solid    = mem_rsp.valid && (mem_rsp.tile != cfg.air) &&
                    (mem_rsp.tile != cfg.leaves);
  assign load_out = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    wdata_nxt     = wdata_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    dt_nxt        = dt_r;
    prod_nxt      = prod_r;
    axis_nxt      = axis_r;
    line_nxt      = line_r;
    c_nxt         = c_r;
    cend_nxt      = cend_r;
    tile_res_nxt  = tile_res_r;
    gnd_nxt       = gnd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mem_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_item.req_type;
          tx_nxt       = in_item.tile_x;
          ty_nxt       = in_item.tile_y;
          wdata_nxt    = in_item.tile_value;
          pos_x_nxt    = in_item.box_x;
          pos_y_nxt    = in_item.box_y;
          w_nxt        = in_item.box_w;
          h_nxt        = in_item.box_h;
          vx_nxt       = in_item.vel_x;
          vy_nxt       = in_item.vel_y;
          dt_nxt       = in_item.step_time;
          axis_nxt     = 1'b0;
          tile_res_nxt = 8'd0;
          gnd_nxt      = 1'b0;
          case (in_item.req_type)
            REQ_WRITE: state_nxt = S_WRITE;
            REQ_READ:  state_nxt = S_RD_ISSUE;
            REQ_MOVE:  state_nxt = S_MUL;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.tx    = tx_r;
        mem_req.ty    = ty_r;
        mem_req.wdata = wdata_r;
        state_nxt     = S_DONE;
      end
      S_RD_ISSUE: begin
        mem_req.en = 1'b1;
        mem_req.tx = tx_r;
        mem_req.ty = ty_r;
        state_nxt  = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        tile_res_nxt = mem_rsp.tile;
        state_nxt    = S_DONE;
      end
      S_MUL: begin
        prod_nxt  = vel_sel * $signed({1'b0, dt_r});
        state_nxt = S_POS;
      end
      S_POS: begin
        if (axis_r) begin
          pos_y_nxt = sat24(29'(moved));
        end else begin
          pos_x_nxt = sat24(29'(moved));
        end
        if (vel_sel != 24'sd0) begin
          state_nxt = S_SETUP;
        end else if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SETUP: begin
        line_nxt  = line_calc;
        c_nxt     = c0_calc;
        cend_nxt  = c1_calc;
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        if (cend_r > span_lim) begin
          cend_nxt = span_lim;
        end
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // One tile read per cycle; each response is checked in the cycle after its read.
        if (issue) begin
          mem_req.en = 1'b1;
          mem_req.tx = axis_r ? c_r : line_r;
          mem_req.ty = axis_r ? line_r : c_r;
          c_nxt      = c_r + 16'sd1;
        end
        if (solid) begin
          state_nxt = S_SNAP;
        end else if (!issue) begin
          if (!axis_r) begin
            axis_nxt  = 1'b1;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SNAP: begin
        if (axis_r) begin
          pos_y_nxt = sat24(face);
          vy_nxt    = 24'sd0;
          gnd_nxt   = !vel_sel[23];
          state_nxt = S_DONE;
        end else begin
          pos_x_nxt = sat24(face);
          vx_nxt    = 24'sd0;
          axis_nxt  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_nxt    = 1'b1;
          out_nxt          = '0;
          out_nxt.tile_out = tile_res_r;
          if (req_r == REQ_MOVE) begin
            out_nxt.new_box_x = pos_x_r;
            out_nxt.new_box_y = pos_y_r;
            out_nxt.new_vel_x = vx_r;
            out_nxt.new_vel_y = vy_r;
            out_nxt.grounded  = gnd_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    wdata_r    <= wdata_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    dt_r       <= dt_nxt;
    prod_r     <= prod_nxt;
    axis_r     <= axis_nxt;
    line_r     <= line_nxt;
    c_r        <= c_nxt;
    cend_r     <= cend_nxt;
    tile_res_r <= tile_res_nxt;
    gnd_r      <= gnd_nxt;
    out_r      <= out_nxt;
  end

endmodule

FILE: rtl/core/tilemap_box_collision.sv
// Top level of the tile map box collision block.
//
// The block holds a MAP_WIDTH x MAP_HEIGHT map of 8-bit tile codes in one
// single-port synchronous memory. Software fills it with write requests before
// use; its content is undefined until written and there is no clearing pass
// after reset. A read request returns one tile (outside the map reads as
// stone_code). A move request advances the box along X, checks the tile column
// at its leading edge, then does the same along Y with the resolved X, snapping
// to the tile face and zeroing the velocity on a solid hit. One request is
// handled at a time; on a move, each axis scans up to MAX_SPAN_TILES+1 tiles
// at one read per cycle through the map's single port. A finished result waits
// in an output register while the next request is accepted. TILE_PIXELS is
// fixed in the package and must be a power of two.
`timescale 1ns / 1ps

module tilemap_box_collision #(
  parameter int MAP_WIDTH      = 256,
  parameter int MAP_HEIGHT     = 128,
  parameter int MAX_SPAN_TILES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  tbc_in_if.sink        in_if,
  tbc_out_if.source     out_if,
  tbc_cfg_if.sink       cfg_if
);
  import tbc_pkg::*;

  cfg_t      cfg;
  mem_req_t  mem_req;
  mem_rsp_t  mem_rsp;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item.req_type   = in_if.req_type;
  assign in_item.tile_x     = in_if.tile_x;
  assign in_item.tile_y     = in_if.tile_y;
  assign in_item.tile_value = in_if.tile_value;
  assign in_item.box_x      = in_if.box_x;
  assign in_item.box_y      = in_if.box_y;
  assign in_item.box_w      = in_if.box_w;
  assign in_item.box_h      = in_if.box_h;
  assign in_item.vel_x      = in_if.vel_x;
  assign in_item.vel_y      = in_if.vel_y;
  assign in_item.step_time  = in_if.step_time;

  assign out_if.tile_out  = out_item.tile_out;
  assign out_if.new_box_x = out_item.new_box_x;
  assign out_if.new_box_y = out_item.new_box_y;
  assign out_if.new_vel_x = out_item.new_vel_x;
  assign out_if.new_vel_y = out_item.new_vel_y;
  assign out_if.grounded  = out_item.grounded;

  tbc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_if.valid),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .wr_ready (cfg_if.ready),
    .cfg      (cfg)
  );

  tbc_tile_store #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (mem_req),
    .stone_code (cfg.stone),
    .rsp        (mem_rsp)
  );

  tbc_ctrl #(
    .MAX_SPAN_TILES (MAX_SPAN_TILES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_item   (in_item),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_item  (out_item),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the tile map box collision block.
`timescale 1ns / 1ps

module tb_top;
  import tbc_pkg::*;

  localparam int MAP_W        = 256;
  localparam int MAP_H        = 128;
  localparam int SPAN_MAX     = 8;
  localparam int REGION_W     = 32;
  localparam int REGION_H     = 16;
  localparam int GROUND_ROW   = 13;
  localparam int TILE_Q8      = TILE_PIXELS * 256;
  localparam int PHASE_ITEMS  = 140;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 50;

  // The request code that the block leaves unused.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct {
    in_item_t  stim;
    bit        fixed;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tbc_in_if  in_ch ();
  tbc_out_if out_ch ();
  tbc_cfg_if cfg_ch ();

  tilemap_box_collision #(
    .MAP_WIDTH      (MAP_W),
    .MAP_HEIGHT     (MAP_H),
    .MAX_SPAN_TILES (SPAN_MAX)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the map and the code registers.
  logic [7:0] map_copy [MAP_W * MAP_H];
  logic [7:0] code_air    = AIR_RESET;
  logic [7:0] code_leaves = LEAVES_RESET;
  logic [7:0] code_stone  = STONE_RESET;

  // Marks the map entries that have been written at least once.
  bit         tile_set [MAP_W * MAP_H];
  bit         touched_unwritten = 1'b0;

  out_item_t pending_results [$];
  dir_row_t  dir_rows [$];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        hold_off_req = 1'b0;

  function automatic bit on_map(input longint tx, input longint ty);
    return tx >= 0 && ty >= 0 && tx < MAP_W && ty < MAP_H;
  endfunction

  function automatic logic [7:0] tile_at(input longint tx, input longint ty);
    if (!on_map(tx, ty)) begin
      return code_stone;
    end
    if (!tile_set[ty * MAP_W + tx]) begin
      touched_unwritten = 1'b1;
    end
    return map_copy[ty * MAP_W + tx];
  endfunction

  function automatic bit is_solid(input longint tx, input longint ty);
    logic [7:0] t;
    t = tile_at(tx, ty);
    return t != code_air && t != code_leaves;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) begin
      return 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      return -64'sd8388608;
    end
    return v;
  endfunction

  // Computes the result of one request and applies its effect on the map copy.
  function automatic out_item_t resolve_request(input in_item_t it);
    out_item_t r;
    longint    tx, ty, bx, by, w, h, vx, vy, dt, nx, ny, lead, line_i, c0, c1, c;
    bit        hit, gnd;
    r   = '0;
    tx  = $signed(it.tile_x);
    ty  = $signed(it.tile_y);
    hit = 1'b0;
    gnd = 1'b0;
    case (it.req_type)
      REQ_WRITE: begin
        if (on_map(tx, ty)) begin
          map_copy[ty * MAP_W + tx] = it.tile_value;
          tile_set[ty * MAP_W + tx] = 1'b1;
        end
      end
      REQ_READ: begin
        r.tile_out = tile_at(tx, ty);
      end
      REQ_MOVE: begin
        bx = $signed(it.box_x);
        by = $signed(it.box_y);
        w  = it.box_w;
        h  = it.box_h;
        vx = $signed(it.vel_x);
        vy = $signed(it.vel_y);
        dt = it.step_time;

        nx = clamp24(bx + ((vx * dt) >>> 16));
        if (vx != 0) begin
          lead   = (vx > 0) ? nx + w : nx;
          line_i = lead >>> TILE_SHIFT;
          c0     = by >>> TILE_SHIFT;
          c1     = (by + h - 1) >>> TILE_SHIFT;
          if (c1 > c0 + SPAN_MAX) begin
            c1 = c0 + SPAN_MAX;
          end
          for (c = c0; c <= c1 && !hit; c++) begin
            hit = is_solid(line_i, c);
          end
          if (hit) begin
            nx = clamp24((vx > 0) ? (line_i <<< TILE_SHIFT) - w
                                  : (line_i + 1) <<< TILE_SHIFT);
            vx = 0;
          end
        end

        hit = 1'b0;
        ny  = clamp24(by + ((vy * dt) >>> 16));
        if (vy != 0) begin
          lead   = (vy > 0) ? ny + h : ny;
          line_i = lead >>> TILE_SHIFT;
          c0     = nx >>> TILE_SHIFT;
          c1     = (nx + w - 1) >>> TILE_SHIFT;
          if (c1 > c0 + SPAN_MAX) begin
            c1 = c0 + SPAN_MAX;
          end
          for (c = c0; c <= c1 && !hit; c++) begin
            hit = is_solid(c, line_i);
          end
          if (hit) begin
            if (vy > 0) begin
              ny  = clamp24((line_i <<< TILE_SHIFT) - h);
              gnd = 1'b1;
            end else begin
              ny = clamp24((line_i + 1) <<< TILE_SHIFT);
            end
            vy = 0;
          end
        end

        r.new_box_x = nx[23:0];
        r.new_box_y = ny[23:0];
        r.new_vel_x = vx[23:0];
        r.new_vel_y = vy[23:0];
        r.grounded  = gnd;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // True when the request would look at a map entry that has never been written.
  function automatic bit reads_unwritten(input in_item_t it);
    if (it.req_type == REQ_WRITE) begin
      return 1'b0;
    end
    touched_unwritten = 1'b0;
    void'(resolve_request(it));
    return touched_unwritten;
  endfunction

  // Mostly air, some leaves, the rest a spread of solid codes.
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 8'd0;
    end else if (r < 72) begin
      return 8'd5;
    end else if (r < 78) begin
      return 8'hFF;
    end else if (r < 84) begin
      return 8'd3;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t tile_req(input logic [1:0] kind, input int tx, input int ty,
                                        input logic [7:0] val);
    in_item_t it;
    it            = '0;
    it.req_type   = kind;
    it.tile_x     = tx[15:0];
    it.tile_y     = ty[15:0];
    it.tile_value = val;
    return it;
  endfunction

  function automatic in_item_t move_req(input int bx, input int by, input int w, input int h,
                                        input int vx, input int vy, input int dt);
    in_item_t it;
    it           = '0;
    it.req_type  = REQ_MOVE;
    it.box_x     = bx[23:0];
    it.box_y     = by[23:0];
    it.box_w     = w[14:0];
    it.box_h     = h[14:0];
    it.vel_x     = vx[23:0];
    it.vel_y     = vy[23:0];
    it.step_time = dt[15:0];
    return it;
  endfunction

  function automatic out_item_t read_result(input logic [7:0] tile);
    out_item_t r;
    r          = '0;
    r.tile_out = tile;
    return r;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 0;
    end else if (r < 80) begin
      return $urandom_range(1, 8191);
    end
    return $urandom_range(8192, 32767);
  endfunction

  function automatic in_item_t draw_request();
    in_item_t     it;
    logic [191:0] noise;
    int           sel, bx, by, vx, vy, dt;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it    = noise[$bits(in_item_t)-1:0];
    sel   = $urandom_range(0, 99);
    if (sel < 8) begin
      // Raw bits in every field, any request code.
    end else if (sel < 18) begin
      it.req_type = REQ_READ;
      it.tile_x   = 16'($urandom_range(0, REGION_W - 1));
      it.tile_y   = 16'($urandom_range(0, REGION_H - 1));
    end else if (sel < 24) begin
      it.req_type = REQ_READ;
    end else if (sel < 30) begin
      it.req_type   = REQ_WRITE;
      it.tile_x     = 16'($urandom_range(0, REGION_W - 1));
      it.tile_y     = 16'($urandom_range(0, REGION_H - 1));
      it.tile_value = pick_code();
    end else if (sel < 33) begin
      it.req_type = REQ_WRITE;
    end else if (sel < 36) begin
      it.req_type = REQ_SPARE;
    end else begin
      bx = int'($urandom_range(0, REGION_W * TILE_Q8 - 1)) - 8192;
      by = int'($urandom_range(0, REGION_H * TILE_Q8 - 1)) - 8192;
      vx = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(0, 800000)) - 400000;
      case ($urandom_range(0, 9))
        0:       vy = 0;
        1, 2, 3: vy = int'($urandom_range(0, 800000)) - 400000;
        default: vy = $urandom_range(1, 400000);
      endcase
      dt = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4000) : $urandom_range(0, 65535);
      it = move_req(bx, by, pick_size(), pick_size(), vx, vy, dt);
    end
    return it;
  endfunction

  // Draws again until the request stays clear of map entries that were never written.
  function automatic in_item_t random_request();
    in_item_t it;
    do begin
      it = draw_request();
    end while (reads_unwritten(it));
    return it;
  endfunction

  task automatic push_item(input in_item_t it, input bit fixed, input out_item_t want);
    int        gap;
    out_item_t model_r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= it.req_type;
    in_ch.tile_x     <= it.tile_x;
    in_ch.tile_y     <= it.tile_y;
    in_ch.tile_value <= it.tile_value;
    in_ch.box_x      <= it.box_x;
    in_ch.box_y      <= it.box_y;
    in_ch.box_w      <= it.box_w;
    in_ch.box_h      <= it.box_h;
    in_ch.vel_x      <= it.vel_x;
    in_ch.vel_y      <= it.vel_y;
    in_ch.step_time  <= it.step_time;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    // The predictor runs on every transaction so that the map copy stays current.
    model_r = resolve_request(it);
    pending_results.push_back(fixed ? want : model_r);
  endtask

  // Stops the sender and waits until every outstanding result has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_codes(input logic [7:0] air, input logic [7:0] leaves,
                             input logic [7:0] stone);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx[0] = CFG_AIR;
    idx[1] = CFG_LEAVES;
    idx[2] = CFG_STONE;
    val[0] = air;
    val[1] = leaves;
    val[2] = stone;
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    code_air    = air;
    code_leaves = leaves;
    code_stone  = stone;
  endtask

  task automatic run_traffic(input int count, input bit pause_mid);
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) begin
        settle();
      end
      push_item(random_request(), 1'b0, '0);
    end
  endtask

  task automatic compare_field(input string name, input logic [23:0] want_v,
                               input logic [23:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $error("%s: expected %h, got %h", name, want_v, got_v);
      end
    end
  endtask

  task automatic take_result();
    out_item_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $error("result transaction with no request outstanding");
      end
    end else begin
      want = pending_results.pop_front();
      compare_field("tile_out", 24'(want.tile_out), 24'(out_ch.tile_out));
      compare_field("new_box_x", want.new_box_x, out_ch.new_box_x);
      compare_field("new_box_y", want.new_box_y, out_ch.new_box_y);
      compare_field("new_vel_x", want.new_vel_x, out_ch.new_vel_x);
      compare_field("new_vel_y", want.new_vel_y, out_ch.new_vel_y);
      compare_field("grounded", 24'(want.grounded), 24'(out_ch.grounded));
    end
  endtask

  // Result side: checks every transaction and stalls in modes that change now and then.
  initial begin
    int hold_left, mode, mode_left;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        take_result();
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 300);
        end
        mode_left--;
        case (mode)
          2:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          3:       out_ch.ready <= ($urandom_range(0, 2) == 0);
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    out_item_t still;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_WRITE;
    in_ch.tile_x     <= '0;
    in_ch.tile_y     <= '0;
    in_ch.tile_value <= '0;
    in_ch.box_x      <= '0;
    in_ch.box_y      <= '0;
    in_ch.box_w      <= '0;
    in_ch.box_h      <= '0;
    in_ch.vel_x      <= '0;
    in_ch.vel_y      <= '0;
    in_ch.step_time  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_AIR;
    cfg_ch.data      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Only the top-left corner of the map is filled, and no random request looks at an
    // entry that was never written. The bottom rows of that corner form a solid floor.
    for (int ty = 0; ty < REGION_H; ty++) begin
      for (int tx = 0; tx < REGION_W; tx++) begin
        push_item(tile_req(REQ_WRITE, tx, ty, (ty >= GROUND_ROW) ? 8'd1 : pick_code()),
                  1'b0, '0);
      end
    end

    still           = '0;
    still.new_box_x = 24'd40960;
    still.new_box_y = 24'd20480;

    dir_rows.push_back('{tile_req(REQ_READ, -1, 0, 0), 1'b1, read_result(STONE_RESET)});
    dir_rows.push_back('{tile_req(REQ_READ, 0, -1, 0), 1'b1, read_result(STONE_RESET)});
    dir_rows.push_back('{tile_req(REQ_READ, MAP_W, 0, 0), 1'b1, read_result(STONE_RESET)});
    dir_rows.push_back('{tile_req(REQ_READ, 0, MAP_H, 0), 1'b1, read_result(STONE_RESET)});
    dir_rows.push_back('{tile_req(REQ_READ, -32768, -32768, 0), 1'b1,
                         read_result(STONE_RESET)});
    dir_rows.push_back('{tile_req(REQ_READ, 32767, 32767, 0), 1'b1, read_result(STONE_RESET)});
    dir_rows.push_back('{tile_req(REQ_WRITE, 0, 0, 8'hAB), 1'b1, '0});
    dir_rows.push_back('{tile_req(REQ_READ, 0, 0, 0), 1'b1, read_result(8'hAB)});
    dir_rows.push_back('{tile_req(REQ_WRITE, MAP_W - 1, MAP_H - 1, 8'hFF), 1'b1, '0});
    dir_rows.push_back('{tile_req(REQ_READ, MAP_W - 1, MAP_H - 1, 0), 1'b1, read_result(8'hFF)});
    // Writes outside the map are dropped; the spot still reads as stone.
    dir_rows.push_back('{tile_req(REQ_WRITE, MAP_W, 5, 8'h5A), 1'b1, '0});
    dir_rows.push_back('{tile_req(REQ_WRITE, -1, -1, 8'h5A), 1'b1, '0});
    dir_rows.push_back('{tile_req(REQ_READ, MAP_W, 5, 0), 1'b1, read_result(STONE_RESET)});
    dir_rows.push_back('{in_item_t'('1), 1'b1, '0});
    // Without velocity the box stays where it is.
    dir_rows.push_back('{move_req(40960, 20480, 4096, 8192, 0, 0, 1092), 1'b1, still});
    dir_rows.push_back('{move_req(40960, 20480, 4096, 4096, 300000, -300000, 0), 1'b0, '0});
    dir_rows.push_back('{move_req(8388607, 8388607, 32767, 32767, 8388607, 8388607, 65535),
                         1'b0, '0});
    dir_rows.push_back('{move_req(-8388608, -8388608, 32767, 32767, -8388608, -8388608, 65535),
                         1'b0, '0});
    dir_rows.push_back('{move_req(409600, 204800, 0, 0, 200000, 200000, 2000), 1'b0, '0});
    dir_rows.push_back('{move_req(60000, 10000, 32767, 32767, -250000, 250000, 3000),
                         1'b0, '0});
    dir_rows.push_back('{move_req(40960, GROUND_ROW * TILE_Q8 - 8192 - 3000, 6000, 8192,
                                  0, 200000, 4000), 1'b0, '0});
    dir_rows.push_back('{move_req(10, 204800, 4096, 4096, -1000000, 0, 65535), 1'b0, '0});
    dir_rows.push_back('{move_req(204800, 10, 4096, 4096, 0, -1000000, 65535), 1'b0, '0});
    dir_rows.push_back('{move_req(MAP_W * TILE_Q8 - 4096 - 10, 204800, 4096, 4096,
                                  1000000, 0, 65535), 1'b0, '0});
    dir_rows.push_back('{tile_req(REQ_READ, REGION_W - 1, 0, 0), 1'b0, '0});

    foreach (dir_rows[i]) begin
      push_item(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);
    end

    run_traffic(PHASE_ITEMS, 1'b0);
    for (int p = 1; p < 6; p++) begin
      settle();
      case (p)
        1:       apply_codes(8'd0, 8'd5, 8'd3);
        2:       apply_codes(8'd255, 8'd0, 8'd0);
        3:       apply_codes(8'd0, 8'd255, 8'd255);
        4:       apply_codes(8'd0, 8'd0, 8'd255);
        default: apply_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
      endcase
      // One long receiver hold-off while requests keep coming, so the input backs up.
      if (p == 2) begin
        hold_off_req = 1'b1;
      end
      run_traffic(PHASE_ITEMS, p == 3);
    end

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
